FILE: src/fhst_pkg.sv
// Shared types and constants for the fermion hop sign tracker.
// Used by fhst_occ_store and the fermion_hop_sign_tracker_unit top level.
package fhst_pkg;

  // Lattice sizing
  localparam int Sites     = 256;
  localparam int Flavours  = 2;
  localparam int SiteW     = 8;
  localparam int FlW       = 1;
  localparam int CntW      = SiteW + 1;

  // Occupancy is kept in rows of RowW sites
  localparam int RowW      = 16;
  localparam int RowBitW   = 4;
  localparam int RowSelW   = SiteW - RowBitW;
  localparam int RowAddrW  = FlW + RowSelW;
  localparam int Rows      = 2 ** RowAddrW;

  // Configuration port
  localparam int CfgAddrW  = 4;
  localparam int CfgDataW  = 32;

  typedef enum logic [1:0] {
    CFG_SITES_A = 2'd0,
    CFG_SITES_B = 2'd1,
    CFG_PART_A  = 2'd2,
    CFG_PART_B  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_HOP  = 1'b1
  } op_e;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CHK  = 7'b0000010,
    ST_DST  = 7'b0000100,
    ST_SCAN = 7'b0001000,
    ST_CLR  = 7'b0010000,
    ST_SET  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  // One access to the occupancy rows: read the row, optionally write one bit
  typedef struct packed {
    logic [RowAddrW-1:0] row;
    logic [RowBitW-1:0]  bit_idx;
    logic                we;
    logic                wval;
  } occ_req_t;

endpackage

FILE: src/fhst_occ_store.sv
// Occupancy row store: flip-flop rows of site occupancy bits, cleared by reset.
// One row read and one single-bit write per cycle. Depends on fhst_pkg.
module fhst_occ_store import fhst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  occ_req_t            req_i,
  output logic [RowW-1:0]     row_o
);

  logic [RowW-1:0] rows_q [Rows];

  // Read the addressed row
  assign row_o = rows_q[req_i.row];

  // Clear on reset, update one bit on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Rows; r++) begin
        rows_q[r] <= '0;
      end
    end else if (req_i.we) begin
      rows_q[req_i.row][req_i.bit_idx] <= req_i.wval;
    end
  end

endmodule

FILE: src/fermion_hop_sign_tracker_unit.sv
// Hops go through the check, destination check, a scan of the rows of 16 sites spanned
// by the hop ends (1..16), clear and set; a shared row reader with a parity unit walks them.
// Loads and items flagged on the source check go from check to done; hops in place and
// hops onto an occupied site end after the destination check. The input stalls until the
// result is registered and takes the next item in the following cycle. Reset sets sites to 256,
// clears occupancy, counters, sign, particle config; site-to-particle memory is not cleared.
module fermion_hop_sign_tracker_unit import fhst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic                 flavour_i,
  input  logic [SiteW-1:0]     from_site_i,
  input  logic [SiteW-1:0]     to_site_i,
  input  logic                 occupied_i,
  // Result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 sign_negative_o,
  output logic                 hop_odd_o,
  output logic [SiteW-1:0]     particle_index_o,
  output logic                 flag_error_o,
  // Configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CfgAddrW-1:0]  paddr,
  input  logic [CfgDataW-1:0]  pwdata,
  output logic [CfgDataW-1:0]  prdata,
  output logic                 pready
);

  localparam logic [CntW-1:0] SitesC = CntW'(Sites);
  localparam logic [CntW-1:0] FlavC  = CntW'(Flavours);
  localparam logic [RowW-1:0] Ones   = {RowW{1'b1}};

  // Configuration registers
  logic [CntW-1:0] sites_a_q, sites_b_q, part_a_q, part_b_q;
  logic            cfg_wr;
  cfg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sites_a_q <= SitesC;
      sites_b_q <= SitesC;
      part_a_q  <= '0;
      part_b_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_SITES_A: sites_a_q <= pwdata[CntW-1:0];
        CFG_SITES_B: sites_b_q <= pwdata[CntW-1:0];
        CFG_PART_A:  part_a_q  <= pwdata[CntW-1:0];
        CFG_PART_B:  part_b_q  <= pwdata[CntW-1:0];
        default:     sites_a_q <= sites_a_q;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      CFG_SITES_A: prdata[CntW-1:0] = sites_a_q;
      CFG_SITES_B: prdata[CntW-1:0] = sites_b_q;
      CFG_PART_A:  prdata[CntW-1:0] = part_a_q;
      CFG_PART_B:  prdata[CntW-1:0] = part_b_q;
      default:     prdata = '0;
    endcase
  end

  // Latched item
  state_e            state_q, state_d;
  logic              op_q, fl_q, occ_in_q;
  logic [SiteW-1:0]  from_q, to_q, lo_q, hi_q;
  logic [RowSelW-1:0] scan_q;
  logic              parity_q, sign_q;
  logic [CntW-1:0]   lc_q [Flavours];
  logic [SiteW-1:0]  sp_rd_q;
  logic [SiteW-1:0]  sp_mem [2 * Sites];

  // Result holding and output registers
  logic              res_odd_q, res_err_q;
  logic [SiteW-1:0]  res_part_q;
  logic              out_valid_q, out_sign_q, out_odd_q, out_err_q;
  logic [SiteW-1:0]  out_part_q;

  logic              in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Effective counts for the latched flavour
  logic [CntW-1:0] sites_raw, part_raw, nsites, npart;
  assign sites_raw = fl_q ? sites_b_q : sites_a_q;
  assign part_raw  = fl_q ? part_b_q  : part_a_q;
  assign nsites    = (sites_raw > SitesC) ? SitesC : sites_raw;
  assign npart     = (part_raw  > SitesC) ? SitesC : part_raw;

  logic fl_bad, from_bad, to_bad;
  assign fl_bad   = (CntW'(fl_q) >= FlavC);
  assign from_bad = ({1'b0, from_q} >= nsites);
  assign to_bad   = ({1'b0, to_q} >= nsites);

  // Load counter after a restart at site zero
  logic [CntW-1:0] lc_eff;
  assign lc_eff = (from_q == '0) ? '0 : lc_q[fl_q];

  // Occupancy store access, address chosen by state
  occ_req_t        occ_req;
  logic [RowW-1:0] occ_row;
  logic            row_bit;

  fhst_occ_store u_occ (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (occ_req),
    .row_o  (occ_row)
  );

  assign row_bit = occ_row[occ_req.bit_idx];

  always_comb begin
    occ_req.row     = {fl_q, from_q[SiteW-1:RowBitW]};
    occ_req.bit_idx = from_q[RowBitW-1:0];
    occ_req.we      = 1'b0;
    occ_req.wval    = 1'b0;
    case (state_q)
      ST_CHK: begin
        // Loads write the site in the same cycle as the check
        if (op_q == OP_LOAD && !fl_bad && !from_bad) begin
          if (!occ_in_q) begin
            occ_req.we = 1'b1;
          end else if (lc_eff < npart) begin
            occ_req.we   = 1'b1;
            occ_req.wval = 1'b1;
          end
        end
      end
      ST_DST: begin
        occ_req.row     = {fl_q, to_q[SiteW-1:RowBitW]};
        occ_req.bit_idx = to_q[RowBitW-1:0];
      end
      ST_SCAN: begin
        occ_req.row = {fl_q, scan_q};
      end
      ST_CLR: begin
        occ_req.we = 1'b1;
      end
      ST_SET: begin
        occ_req.row     = {fl_q, to_q[SiteW-1:RowBitW]};
        occ_req.bit_idx = to_q[RowBitW-1:0];
        occ_req.we      = 1'b1;
        occ_req.wval    = 1'b1;
      end
      default: occ_req.we = 1'b0;
    endcase
  end

  // Mask the scanned row to sites strictly between the hop ends
  logic [RowW-1:0] scan_mask;
  logic            scan_par, scan_last;
  assign scan_last = (scan_q == hi_q[SiteW-1:RowBitW]);
  always_comb begin
    scan_mask = Ones;
    if (scan_q == lo_q[SiteW-1:RowBitW]) begin
      scan_mask = scan_mask & (Ones << (lo_q[RowBitW-1:0] + RowBitW'(1)));
      if (lo_q[RowBitW-1:0] == {RowBitW{1'b1}}) begin
        scan_mask = '0;
      end
    end
    if (scan_last) begin
      scan_mask = scan_mask & ~(Ones << hi_q[RowBitW-1:0]);
    end
  end
  assign scan_par = ^(occ_row & scan_mask);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_CHK;
      ST_CHK: begin
        if (op_q == OP_HOP && !fl_bad && !from_bad && !to_bad && row_bit) begin
          state_d = ST_DST;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DST: begin
        if (from_q == to_q || row_bit) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: if (scan_last) state_d = ST_CLR;
      ST_CLR:  state_d = ST_SET;
      ST_SET:  state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int f = 0; f < Flavours; f++) begin
        lc_q[f] <= '0;
      end
    end else begin
      state_q <= state_d;
      // Restart numbering and count loaded particles
      if (state_q == ST_CHK && op_q == OP_LOAD && !fl_bad && !from_bad) begin
        if (occ_in_q && lc_eff < npart) begin
          lc_q[fl_q] <= lc_eff + CntW'(1);
        end else begin
          lc_q[fl_q] <= lc_eff;
        end
      end
      // Flip the sign on an odd hop
      if (state_q == ST_SET) begin
        sign_q <= sign_q ^ parity_q;
      end
      // Hand the result to the output register
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= operation_i;
      fl_q     <= flavour_i;
      from_q   <= from_site_i;
      to_q     <= to_site_i;
      occ_in_q <= occupied_i;
    end
    case (state_q)
      ST_CHK: begin
        res_odd_q <= 1'b0;
        if (fl_bad || from_bad) begin
          res_err_q  <= 1'b1;
          res_part_q <= '0;
        end else if (op_q == OP_LOAD) begin
          if (occ_in_q && lc_eff < npart) begin
            res_err_q  <= 1'b0;
            res_part_q <= lc_eff[SiteW-1:0];
          end else begin
            // an occupied load past the particle count is rejected
            res_err_q  <= occ_in_q;
            res_part_q <= '0;
          end
        end else begin
          res_err_q  <= to_bad || !row_bit;
          res_part_q <= '0;
        end
      end
      ST_DST: begin
        lo_q     <= (from_q < to_q) ? from_q : to_q;
        hi_q     <= (from_q < to_q) ? to_q : from_q;
        scan_q   <= (from_q < to_q) ? from_q[SiteW-1:RowBitW] : to_q[SiteW-1:RowBitW];
        parity_q <= 1'b0;
        if (from_q == to_q) begin
          res_part_q <= sp_rd_q;
        end else if (row_bit) begin
          res_err_q <= 1'b1;
        end else begin
          res_part_q <= sp_rd_q;
        end
      end
      ST_SCAN: begin
        parity_q <= parity_q ^ scan_par;
        scan_q   <= scan_q + RowSelW'(1);
      end
      ST_SET: begin
        res_odd_q <= parity_q;
      end
      ST_DONE: begin
        if (out_free) begin
          out_sign_q <= sign_q;
          out_odd_q  <= res_odd_q;
          out_part_q <= res_part_q;
          out_err_q  <= res_err_q;
        end
      end
      default: parity_q <= parity_q;
    endcase
  end

  // Site-to-particle memory, registered read
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHK) begin
      sp_rd_q <= sp_mem[{fl_q, from_q}];
    end
    if (state_q == ST_CHK && op_q == OP_LOAD && !fl_bad && !from_bad &&
        occ_in_q && lc_eff < npart) begin
      sp_mem[{fl_q, from_q}] <= lc_eff[SiteW-1:0];
    end else if (state_q == ST_SET) begin
      sp_mem[{fl_q, to_q}] <= res_part_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sign_negative_o  = out_sign_q;
  assign hop_odd_o        = out_odd_q;
  assign particle_index_o = out_part_q;
  assign flag_error_o     = out_err_q;

endmodule

FILE: src/fhst_checker.sv
// Port-level checks for fermion_hop_sign_tracker_unit, attached by bind.
// Depends on fhst_pkg for field widths.
module fhst_checker import fhst_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                operation_i,
  input logic                flavour_i,
  input logic [SiteW-1:0]    from_site_i,
  input logic [SiteW-1:0]    to_site_i,
  input logic                occupied_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic                sign_negative_o,
  input logic                hop_odd_o,
  input logic [SiteW-1:0]    particle_index_o,
  input logic                flag_error_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sign_negative_o) &&
    $stable(hop_odd_o) && $stable(particle_index_o) && $stable(flag_error_o))
    else $error("stalled result changed");

  // Keep a stalled input item offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(operation_i) &&
    $stable(flavour_i) && $stable(from_site_i) && $stable(to_site_i) &&
    $stable(occupied_i))
    else $error("stalled input item dropped or changed");

  // Go busy after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // Drive fixed fields on a rejected item
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flag_error_o |-> !hop_odd_o && particle_index_o == '0)
    else $error("rejected item carries hop data");

endmodule

bind fermion_hop_sign_tracker_unit fhst_checker u_fhst_checker (.*);
